[design/gin_pkg.sv]
package gin_pkg;

    localparam int DIM_BITS = 16;
    localparam int DW       = DIM_BITS + 1;
    localparam int FLAT_W   = 32;

    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = FLAT_W / DIV_STEPS;

    localparam int IN_DATA_W  = ((2 * DW + FLAT_W + 3 + 1 + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * DW + FLAT_W + 7) / 8) * 8;

    localparam logic [1:0] MODE_C2F = 2'd0;
    localparam logic [1:0] MODE_F2C = 2'd1;
    localparam logic [1:0] MODE_NAV = 2'd2;

    localparam logic [2:0] DIR_LEFT  = 3'd0;
    localparam logic [2:0] DIR_RIGHT = 3'd1;
    localparam logic [2:0] DIR_UP    = 3'd2;
    localparam logic [2:0] DIR_DOWN  = 3'd3;
    localparam logic [2:0] DIR_NEXT  = 3'd4;
    localparam logic [2:0] DIR_PREV  = 3'd5;

    // Item state carried through the late stages and the divider.
    typedef struct packed {
        logic [1:0]          mode;
        logic                ok;
        logic [DW-1:0]       row;
        logic [DW-1:0]       col;
        logic [FLAT_W-1:0]   flat;
        logic [FLAT_W-1:0]   work;
        logic [DIM_BITS-1:0] rem;
    } pipe_t;

endpackage

[design/grid_index_and_navigation_unit.sv]
// Channel   | Ports            | Content (lowest bit up)
// ----------+------------------+---------------------------------------------------
// input     | s_t*             | tuser: mode; tdata: cell_row, cell_col, flat_index,
//           |                  |        direction, wrap
// result    | m_t*             | tuser: success; tdata: res_row, res_col, res_flat
// config    | APB p*           | 0x0 row_count, 0x4 col_count
//
// Eleven register stages: capture, multiply, evaluate, then eight divider
// stages of four quotient bits each. One transfer per cycle is sustained
// while m_tready is high. Each stage holds while the stage after it is
// full and stalled, so bubbles close up during a stall and nothing is lost
// or repeated. Synchronous active-low reset clears the valid bits and the
// grid sizes. Change the sizes only while the pipeline is empty.
module grid_index_and_navigation_unit
    import gin_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cell_row, cell_col, flat_index, direction, wrap
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // res_row, res_col, res_flat
    output logic [OUT_DATA_W-1:0] m_tdata,
    // success
    output logic [0:0]            m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // Configuration registers
    logic [DIM_BITS-1:0] rows_reg, cols_reg;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'(cols_reg) : 32'(rows_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= '0;
            cols_reg <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) cols_reg <= pwdata[DIM_BITS-1:0];
            else          rows_reg <= pwdata[DIM_BITS-1:0];
        end
    end

    // Flow control: a stage advances when it is empty or its successor advances
    logic                  v1_reg, v2_reg, v3_reg;
    logic [DIV_STAGES-1:0] dv_reg;
    logic [DIV_STAGES-1:0] dv_in;
    logic                  rdy1, rdy2, rdy3;
    logic [DIV_STAGES-1:0] rdy_d;

    always_comb begin
        rdy_d[DIV_STAGES-1] = !dv_reg[DIV_STAGES-1] || m_tready;
        for (int i = DIV_STAGES - 2; i >= 0; i--)
            rdy_d[i] = !dv_reg[i] || rdy_d[i+1];
    end
    assign rdy3 = !v3_reg || rdy_d[0];
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // Stage 1: capture the transfer
    logic [1:0]               mode1_reg;
    logic signed [DW-1:0]     cr1_reg, cc1_reg;
    logic signed [FLAT_W-1:0] fi1_reg;
    logic [2:0]               dir1_reg;
    logic                     wrap1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (rdy1) v1_reg <= s_tvalid;
        if (rdy1) begin
            mode1_reg <= s_tuser;
            cr1_reg   <= s_tdata[DW-1:0];
            cc1_reg   <= s_tdata[2*DW-1:DW];
            fi1_reg   <= s_tdata[2*DW+FLAT_W-1:2*DW];
            dir1_reg  <= s_tdata[2*DW+FLAT_W+2:2*DW+FLAT_W];
            wrap1_reg <= s_tdata[2*DW+FLAT_W+3];
        end
    end

    // Stage 2: products, bounds and clamping
    logic [1:0]                mode2_reg;
    logic [DIM_BITS-1:0]       cc2_reg;
    logic signed [FLAT_W-1:0]  fi2_reg;
    logic [2:0]                dir2_reg;
    logic                      wrap2_reg;
    logic [2*DIM_BITS-1:0]     area2_reg, pcell2_reg;
    logic                      inb2_reg;
    logic [DIM_BITS-1:0]       rc2_reg, cl2_reg;
    logic [DIM_BITS-1:0]       rc_next, cl_next;
    logic                      row_in, col_in;

    assign row_in = !cr1_reg[DW-1] && (cr1_reg < $signed({1'b0, rows_reg}));
    assign col_in = !cc1_reg[DW-1] && (cc1_reg < $signed({1'b0, cols_reg}));

    always_comb begin
        if (cr1_reg[DW-1])    rc_next = '0;
        else if (!row_in)     rc_next = rows_reg - 1'b1;
        else                  rc_next = cr1_reg[DIM_BITS-1:0];
        if (cc1_reg[DW-1])    cl_next = '0;
        else if (!col_in)     cl_next = cols_reg - 1'b1;
        else                  cl_next = cc1_reg[DIM_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (rdy2) v2_reg <= v1_reg;
        if (rdy2) begin
            mode2_reg  <= mode1_reg;
            cc2_reg    <= cc1_reg[DIM_BITS-1:0];
            fi2_reg    <= fi1_reg;
            dir2_reg   <= dir1_reg;
            wrap2_reg  <= wrap1_reg;
            area2_reg  <= rows_reg * cols_reg;
            pcell2_reg <= cr1_reg[DIM_BITS-1:0] * cols_reg;
            inb2_reg   <= row_in && col_in;
            rc2_reg    <= rc_next;
            cl2_reg    <= cl_next;
        end
    end

    // Stage 3: finish cell-to-flat and navigation, check and load the divider
    pipe_t                 s3_next, s3_reg;
    logic [2*DIM_BITS:0]   flat_sum;
    logic                  empty;
    logic [DIM_BITS-1:0]   rm1, cm1, nr, nc;
    logic                  nav_ok;

    assign flat_sum = {1'b0, pcell2_reg} + (2*DIM_BITS+1)'(cc2_reg);
    assign empty    = (rows_reg == '0) || (cols_reg == '0);
    assign rm1      = rows_reg - 1'b1;
    assign cm1      = cols_reg - 1'b1;

    always_comb begin
        nr = rc2_reg;
        nc = cl2_reg;
        nav_ok = 1'b1;
        case (dir2_reg)
            DIR_LEFT: begin
                if (nc != '0) nc = nc - 1'b1;
                else if (wrap2_reg) begin
                    nr = (nr != '0) ? nr - 1'b1 : rm1;
                    nc = cm1;
                end else nav_ok = 1'b0;
            end
            DIR_RIGHT: begin
                if (nc < cm1) nc = nc + 1'b1;
                else if (wrap2_reg) begin
                    nr = (nr < rm1) ? nr + 1'b1 : '0;
                    nc = '0;
                end else nav_ok = 1'b0;
            end
            DIR_UP: begin
                if (nr != '0) nr = nr - 1'b1;
                else if (wrap2_reg) nr = rm1;
                else nav_ok = 1'b0;
            end
            DIR_DOWN: begin
                if (nr < rm1) nr = nr + 1'b1;
                else if (wrap2_reg) nr = '0;
                else nav_ok = 1'b0;
            end
            DIR_NEXT: begin
                if (nc < cm1) nc = nc + 1'b1;
                else if (nr < rm1) begin
                    nr = nr + 1'b1;
                    nc = '0;
                end else if (wrap2_reg) begin
                    nr = '0;
                    nc = '0;
                end else nav_ok = 1'b0;
            end
            DIR_PREV: begin
                if (nc != '0) nc = nc - 1'b1;
                else if (nr != '0) begin
                    nr = nr - 1'b1;
                    nc = cm1;
                end else if (wrap2_reg) begin
                    nr = rm1;
                    nc = cm1;
                end else nav_ok = 1'b0;
            end
            default: nav_ok = 1'b0;
        endcase

        s3_next      = '0;
        s3_next.mode = mode2_reg;
        s3_next.row  = '1;
        s3_next.col  = '1;
        s3_next.flat = '1;
        s3_next.work = fi2_reg;
        s3_next.rem  = '0;
        case (mode2_reg)
            MODE_C2F: begin
                if (inb2_reg && (64'(flat_sum) <= 64'(32'h7fff_ffff))) begin
                    s3_next.ok   = 1'b1;
                    s3_next.flat = FLAT_W'(64'(flat_sum));
                end
            end
            MODE_F2C: begin
                s3_next.ok = !empty && !fi2_reg[FLAT_W-1]
                             && (64'(fi2_reg) < 64'(area2_reg));
            end
            MODE_NAV: begin
                if (!empty && nav_ok) begin
                    s3_next.ok  = 1'b1;
                    s3_next.row = DW'(nr);
                    s3_next.col = DW'(nc);
                end
            end
            default: s3_next.ok = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (rdy3) v3_reg <= v2_reg;
        if (rdy3) s3_reg <= s3_next;
    end

    // Divider stages: flat index over column count, four quotient bits a stage
    pipe_t dstg_reg [DIV_STAGES];
    pipe_t dstg_in  [DIV_STAGES];
    pipe_t dstg_out [DIV_STAGES];
    pipe_t dstg_next[DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_div
            if (g == 0) begin : g_first
                assign dstg_in[g] = s3_reg;
                assign dv_in[g]   = v3_reg;
            end else begin : g_rest
                assign dstg_in[g] = dstg_reg[g-1];
                assign dv_in[g]   = dv_reg[g-1];
            end

            gin_div_stage u_stage (
                .din     (dstg_in[g]),
                .divisor (cols_reg),
                .dout    (dstg_out[g])
            );

            if (g == DIV_STAGES - 1) begin : g_last
                // Drop quotient and remainder into the result for a good conversion
                always_comb begin
                    dstg_next[g] = dstg_out[g];
                    if (dstg_out[g].mode == MODE_F2C && dstg_out[g].ok) begin
                        dstg_next[g].row = DW'(dstg_out[g].work[DIM_BITS-1:0]);
                        dstg_next[g].col = DW'(dstg_out[g].rem);
                    end
                end
            end else begin : g_mid
                assign dstg_next[g] = dstg_out[g];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) dv_reg[g] <= 1'b0;
                else if (rdy_d[g]) dv_reg[g] <= dv_in[g];
                if (rdy_d[g]) dstg_reg[g] <= dstg_next[g];
            end
        end
    endgenerate

    // Result channel straight from the last stage register
    assign m_tvalid   = dv_reg[DIV_STAGES-1];
    assign m_tuser[0] = dstg_reg[DIV_STAGES-1].ok;
    assign m_tdata    = OUT_DATA_W'({dstg_reg[DIV_STAGES-1].flat,
                                     dstg_reg[DIV_STAGES-1].col,
                                     dstg_reg[DIV_STAGES-1].row});

endmodule

[design/gin_div_stage.sv]
module gin_div_stage
    import gin_pkg::*;
(
    input  pipe_t               din,
    input  logic [DIM_BITS-1:0] divisor,
    output pipe_t               dout
);

    logic [DIM_BITS:0]   trial;
    logic [DIM_BITS-1:0] rem;
    logic [FLAT_W-1:0]   work;

    // Restoring division: shift one dividend bit into the remainder, subtract
    // when it fits, shift the quotient bit into the freed low end.
    always_comb begin
        rem  = din.rem;
        work = din.work;
        trial = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial = {rem, work[FLAT_W-1]};
            if (trial >= {1'b0, divisor}) begin
                trial = trial - {1'b0, divisor};
                work  = {work[FLAT_W-2:0], 1'b1};
            end else begin
                work  = {work[FLAT_W-2:0], 1'b0};
            end
            rem = trial[DIM_BITS-1:0];
        end
        dout      = din;
        dout.rem  = rem;
        dout.work = work;
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

// Testbench for the grid address unit: drives conversions and navigation steps through
// the input stream, predicts each result in behavioral code and compares it, field by
// field, with the result stream in transfer order.
module tb;
    import gin_pkg::*;

    localparam int LATENCY    = 11;
    localparam int CYCLE_CAP  = 400000;
    localparam int RAND_ITEMS = 1000;
    localparam logic [2:0] ADDR_ROWS = 3'd0;
    localparam logic [2:0] ADDR_COLS = 3'd4;

    typedef struct packed {
        logic              success;
        logic [DW-1:0]     row;
        logic [DW-1:0]     col;
        logic [FLAT_W-1:0] flat;
    } grid_result_t;

    typedef struct {
        logic [1:0]        mode;
        logic [DW-1:0]     crow;
        logic [DW-1:0]     ccol;
        logic [FLAT_W-1:0] fidx;
        logic [2:0]        dir;
        logic              wrap;
        logic              has_known;
        grid_result_t      known;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    grid_index_and_navigation_unit uut (.*);

    always #5 aclk = ~aclk;

    // grid size as the predictor sees it
    longint       rows_now;
    longint       cols_now;
    grid_result_t pending_results[$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           sender_idle_pct = 0;
    int           receiver_idle_pct = 0;

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Behavioral prediction of one item against the current grid size.
    function automatic grid_result_t predict_grid(logic [1:0] mode, logic [DW-1:0] crow,
                                                  logic [DW-1:0] ccol,
                                                  logic [FLAT_W-1:0] fidx,
                                                  logic [2:0] dir, logic wrap);
        longint r;
        longint c;
        longint f;
        longint rr;
        longint rc;
        longint rf;
        longint fi;
        bit ok;
        grid_result_t res;
        r  = longint'($signed(crow));
        c  = longint'($signed(ccol));
        fi = longint'($signed(fidx));
        rr = -1;
        rc = -1;
        rf = -1;
        ok = 0;
        case (mode)
            MODE_C2F: begin
                if (r >= 0 && r < rows_now && c >= 0 && c < cols_now) begin
                    f = r * cols_now + c;
                    if (f <= 64'sd2147483647) begin
                        rf = f;
                        ok = 1;
                    end
                end
            end
            MODE_F2C: begin
                if (rows_now > 0 && cols_now > 0 && fi >= 0 && fi < rows_now * cols_now) begin
                    rr = fi / cols_now;
                    rc = fi % cols_now;
                    ok = 1;
                end
            end
            MODE_NAV: begin
                if (rows_now > 0 && cols_now > 0) begin
                    r  = clamp_to(r, 0, rows_now - 1);
                    c  = clamp_to(c, 0, cols_now - 1);
                    ok = 1;
                    case (dir)
                        DIR_LEFT: begin
                            if (c > 0) c--;
                            else if (wrap) begin
                                r = r > 0 ? r - 1 : rows_now - 1;
                                c = cols_now - 1;
                            end else ok = 0;
                        end
                        DIR_RIGHT: begin
                            if (c < cols_now - 1) c++;
                            else if (wrap) begin
                                r = r < rows_now - 1 ? r + 1 : 0;
                                c = 0;
                            end else ok = 0;
                        end
                        DIR_UP: begin
                            if (r > 0) r--;
                            else if (wrap) r = rows_now - 1;
                            else ok = 0;
                        end
                        DIR_DOWN: begin
                            if (r < rows_now - 1) r++;
                            else if (wrap) r = 0;
                            else ok = 0;
                        end
                        DIR_NEXT: begin
                            f = r * cols_now + c + 1;
                            if (f >= rows_now * cols_now) begin
                                if (wrap) begin
                                    r = 0;
                                    c = 0;
                                end else ok = 0;
                            end else begin
                                r = f / cols_now;
                                c = f % cols_now;
                            end
                        end
                        DIR_PREV: begin
                            f = r * cols_now + c - 1;
                            if (f < 0) begin
                                if (wrap) begin
                                    r = rows_now - 1;
                                    c = cols_now - 1;
                                end else ok = 0;
                            end else begin
                                r = f / cols_now;
                                c = f % cols_now;
                            end
                        end
                        default: ok = 0;
                    endcase
                    if (ok) begin
                        rr = r;
                        rc = c;
                    end
                end
            end
            default: ;
        endcase
        res.success = ok;
        res.row     = rr[DW-1:0];
        res.col     = rc[DW-1:0];
        res.flat    = rf[FLAT_W-1:0];
        return res;
    endfunction

    // Cycle counter; abort on runaway.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("grid_index_and_navigation_unit: mismatch");
            $finish;
        end
    end

    // Result side: random stall, then compare each transfer with the oldest prediction.
    always @(posedge aclk) begin
        grid_result_t got;
        grid_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.success = m_tuser[0];
            got.row     = m_tdata[DW-1:0];
            got.col     = m_tdata[2*DW-1:DW];
            got.flat    = m_tdata[2*DW+FLAT_W-1:2*DW];
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: success %0d row %0d col %0d flat %0d",
                       got.success, $signed(got.row), $signed(got.col), $signed(got.flat));
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.success !== want.success) begin
                    $error("success: expected %0d, got %0d", want.success, got.success);
                    error_count++;
                end
                if (got.row !== want.row) begin
                    $error("res_row: expected %0d, got %0d", $signed(want.row),
                           $signed(got.row));
                    error_count++;
                end
                if (got.col !== want.col) begin
                    $error("res_col: expected %0d, got %0d", $signed(want.col),
                           $signed(got.col));
                    error_count++;
                end
                if (got.flat !== want.flat) begin
                    $error("res_flat: expected %0d, got %0d", $signed(want.flat),
                           $signed(got.flat));
                    error_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Write one register: setup cycle, then access cycle.
    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ROWS) rows_now = value[DIM_BITS-1:0];
        else cols_now = value[DIM_BITS-1:0];
    endtask

    // Wait for the pipeline to drain before touching the grid size.
    task automatic drain_pipeline();
        wait (pending_results.size() == 0);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic set_grid(int rows, int cols);
        drain_pipeline();
        write_reg(ADDR_ROWS, rows);
        write_reg(ADDR_COLS, cols);
    endtask

    // Offer one item with a random sender gap; hold it until the transfer.
    task automatic send_item(logic [1:0] mode, logic [DW-1:0] crow, logic [DW-1:0] ccol,
                             logic [FLAT_W-1:0] fidx, logic [2:0] dir, logic wrap);
        logic [IN_DATA_W-1:0] data;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        data = '0;
        data[DW-1:0]                    = crow;
        data[2*DW-1:DW]                 = ccol;
        data[2*DW+FLAT_W-1:2*DW]        = fidx;
        data[2*DW+FLAT_W+2:2*DW+FLAT_W] = dir;
        data[2*DW+FLAT_W+3]             = wrap;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        pending_results.push_back(predict_grid(mode, crow, ccol, fidx, dir, wrap));
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    // Cell values mostly near the grid, sometimes anywhere in the field's range.
    function automatic logic [DW-1:0] pick_coord(longint limit);
        case ($urandom_range(9))
            0:       return DW'($urandom());
            1:       return DW'(-$urandom_range(3));
            default: return DW'($urandom_range(32'(limit > 0 ? limit : 2)));
        endcase
    endfunction

    function automatic logic [FLAT_W-1:0] pick_flat();
        longint area;
        area = rows_now * cols_now;
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return -$urandom_range(3);
            2:       return area[31:0] + $urandom_range(2);
            default: return area > 0 ? $urandom_range(32'(area - 1)) : $urandom_range(4);
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [1:0] mode;
        logic [2:0] dir;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(15) == 0 ? 2'd3 : 2'($urandom_range(2));
            dir  = $urandom_range(9) == 0 ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
            send_item(mode, pick_coord(rows_now), pick_coord(cols_now), pick_flat(), dir,
                      1'($urandom_range(1)));
        end
        end_burst();
    endtask

    stim_row_t directed[$];

    function automatic stim_row_t mk(logic [1:0] m, int r, int c, int f, logic [2:0] d,
                                     logic w, logic k, logic ks, int kr, int kc, int kf);
        stim_row_t s;
        s.mode = m;
        s.crow = r[DW-1:0];
        s.ccol = c[DW-1:0];
        s.fidx = f;
        s.dir  = d;
        s.wrap = w;
        s.has_known = k;
        s.known = '{ks, kr[DW-1:0], kc[DW-1:0], kf[FLAT_W-1:0]};
        return s;
    endfunction

    initial begin
        grid_result_t fixed;
        rows_now = 0;
        cols_now = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty grid after reset: everything fails.
        directed.push_back(mk(MODE_C2F, 0, 0, 0, DIR_LEFT, 0, 1, 0, -1, -1, -1));
        directed.push_back(mk(MODE_F2C, 0, 0, 0, DIR_LEFT, 0, 1, 0, -1, -1, -1));
        directed.push_back(mk(MODE_NAV, 0, 0, 0, DIR_NEXT, 1, 1, 0, -1, -1, -1));
        foreach (directed[i]) begin
            fixed = directed[i].known;
            send_item(directed[i].mode, directed[i].crow, directed[i].ccol,
                      directed[i].fidx, directed[i].dir, directed[i].wrap);
            if (directed[i].has_known && pending_results[$] !== fixed) begin
                $error("directed row %0d: predictor disagrees with typed result", i);
                error_count++;
            end
        end
        end_burst();

        // Maximum grid: overflow of the flat index, extremes of every field.
        set_grid(65535, 65535);
        directed.delete();
        directed.push_back(mk(MODE_C2F, 65534, 65534, 0, DIR_LEFT, 0, 1, 0, -1, -1, -1));
        directed.push_back(mk(MODE_C2F, 0, 65534, 0, DIR_LEFT, 0, 1, 1, -1, -1, 65534));
        directed.push_back(mk(MODE_C2F, -65536, 0, 0, DIR_LEFT, 0, 1, 0, -1, -1, -1));
        directed.push_back(mk(MODE_C2F, 0, 65535, 0, DIR_LEFT, 0, 1, 0, -1, -1, -1));
        directed.push_back(mk(MODE_F2C, 0, 0, 32'h7FFFFFFF, DIR_LEFT, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(MODE_F2C, 0, 0, 32'h80000000, DIR_LEFT, 0, 1, 0, -1, -1, -1));
        directed.push_back(mk(MODE_F2C, 0, 0, -1, DIR_LEFT, 0, 1, 0, -1, -1, -1));
        directed.push_back(mk(MODE_NAV, 65535, -65536, 0, DIR_LEFT, 1, 0, 0, 0, 0, 0));
        directed.push_back(mk(MODE_NAV, 0, 0, 0, DIR_UP, 0, 1, 0, -1, -1, -1));
        directed.push_back(mk(MODE_NAV, 0, 0, 0, DIR_PREV, 1, 1, 1, 65534, 65534, -1));
        directed.push_back(mk(MODE_NAV, 65534, 65534, 0, DIR_NEXT, 1, 1, 1, 0, 0, -1));
        directed.push_back(mk(MODE_NAV, 1, 1, 0, 3'd6, 1, 1, 0, -1, -1, -1));
        directed.push_back(mk(MODE_NAV, 1, 1, 0, 3'd7, 0, 1, 0, -1, -1, -1));
        directed.push_back(mk(2'd3, 1, 1, 5, DIR_LEFT, 0, 1, 0, -1, -1, -1));
        foreach (directed[i]) begin
            fixed = directed[i].known;
            send_item(directed[i].mode, directed[i].crow, directed[i].ccol,
                      directed[i].fidx, directed[i].dir, directed[i].wrap);
            if (directed[i].has_known && pending_results[$] !== fixed) begin
                $error("directed row %0d: predictor disagrees with typed result", i);
                error_count++;
            end
        end
        end_burst();

        // Small grid: every direction with and without wrap at corners.
        set_grid(3, 4);
        for (int d = 0; d < 6; d++)
            for (int w = 0; w < 2; w++) begin
                send_item(MODE_NAV, DW'((d % 2) ? 2 : 0), DW'((d % 2) ? 3 : 0), '0,
                          3'(d), 1'(w));
            end
        end_burst();

        // Random phases over several grid sizes and idle profiles.
        sender_idle_pct   = 28;
        receiver_idle_pct = 67;
        set_grid(1, 1);
        random_phase(RAND_ITEMS / 8);
        set_grid($urandom_range(2, 20), $urandom_range(2, 20));
        random_phase(RAND_ITEMS / 8);
        set_grid(65535, 1);
        random_phase(RAND_ITEMS / 8);
        sender_idle_pct   = 67;
        receiver_idle_pct = 28;
        set_grid(0, 9);
        random_phase(RAND_ITEMS / 8);
        set_grid(40000, 60000);
        random_phase(RAND_ITEMS / 8);
        set_grid(1, 65535);
        random_phase(RAND_ITEMS / 8);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        set_grid($urandom_range(1, 300), $urandom_range(1, 300));
        random_phase(RAND_ITEMS / 8);
        set_grid($urandom_range(65535), $urandom_range(65535));
        random_phase(RAND_ITEMS / 8);

        drain_pipeline();
        if (error_count == 0) begin
            $display("grid_index_and_navigation_unit: match");
        end else begin
            $display("grid_index_and_navigation_unit: mismatch");
        end
        $finish;
    end
endmodule

[files.f]
design/gin_pkg.sv
design/gin_div_stage.sv
design/grid_index_and_navigation_unit.sv
tb/sv/tb.sv
